// ----- rtl/core/arp_responder_and_cache_macros.svh -----
// Assertion macros shared by the ARP responder and cache RTL.
// Depends on nothing; included by the top level only.
`ifndef ARP_RESPONDER_AND_CACHE_MACROS_SVH
`define ARP_RESPONDER_AND_CACHE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/arc_pkg.sv -----
// Package for the ARP responder and cache: sizes, protocol codes,
// register indexes and the controller/datapath interface structs.
package arc_pkg;

   localparam int CACHE_ENTRIES = 32;
   localparam int IDX_W         = $clog2(CACHE_ENTRIES);
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 64;

   localparam logic [10:0] MIN_ARP_LENGTH   = 11'd28;
   localparam logic [15:0] HW_TYPE_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_TYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  HW_LEN_ETHERNET  = 8'd6;
   localparam logic [7:0]  PROTO_LEN_IPV4   = 8'd4;
   localparam logic [15:0] OP_REQUEST       = 16'd1;
   localparam logic [15:0] OP_REPLY         = 16'd2;

   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Register index is paddr[3] (registers sit 8 bytes apart).
   localparam logic REG_OWN_IP  = 1'b0;
   localparam logic REG_OWN_MAC = 1'b1;

   typedef struct packed {
      logic capture;   // latch the accepted transaction
      logic exec;      // search cache, update it, latch flags
      logic load;      // move the finished result to the output register
   } arc_cmd_type;

   typedef struct packed {
      logic rsp_busy;  // output register holds a result not yet taken
   } arc_status_type;

endpackage

// ----- rtl/core/arc_ctrl.sv -----
// Sequencer of the ARP responder and cache: accept, execute, deliver.
// Depends on arc_pkg for the command and status structs.
module arc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    rsp_stall,
   input  arc_pkg::arc_status_type status,
   output arc_pkg::arc_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       slot_free;
   logic       accept;

   // Output slot frees up when it is empty or its result leaves this edge.
   assign slot_free = !status.rsp_busy || !rsp_stall;

   assign cmd.load    = (state_ff == ST_FIN) && slot_free;
   assign req_stall   = !((state_ff == ST_IDLE) || cmd.load);
   assign accept      = req_valid && !req_stall;
   assign cmd.capture = accept;
   assign cmd.exec    = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (cmd.load) state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/arc_datapath.sv -----
// Datapath of the ARP responder and cache: transaction latch, header check,
// parallel cache compare, cache storage and output register. Uses arc_pkg.
module arc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  arc_pkg::arc_cmd_type    cmd,
   output arc_pkg::arc_status_type status,
   input  logic [31:0]             own_ip,
   input  logic                    req_command,
   input  logic [10:0]             req_payload_length,
   input  logic [15:0]             req_hardware_type,
   input  logic [15:0]             req_protocol_type,
   input  logic [7:0]              req_hardware_length,
   input  logic [7:0]              req_protocol_length,
   input  logic [15:0]             req_operation,
   input  logic [31:0]             req_sender_ip,
   input  logic [47:0]             req_sender_mac,
   input  logic [31:0]             req_target_ip,
   input  logic [31:0]             req_lookup_ip,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_send_reply,
   output logic [47:0]             rsp_reply_dest_mac,
   output logic [31:0]             rsp_reply_dest_ip,
   output logic                    rsp_learned,
   output logic                    rsp_learn_dropped,
   output logic                    rsp_lookup_hit,
   output logic [47:0]             rsp_lookup_mac
);

   // Latched transaction
   logic        command_ff;
   logic        header_ok_ff;
   logic [15:0] operation_ff;
   logic [31:0] sender_ip_ff;
   logic [47:0] sender_mac_ff;
   logic [31:0] target_ip_ff;
   logic [31:0] lookup_ip_ff;
   logic        header_ok_in;

   // Cache
   logic [31:0] entry_ip_ff [arc_pkg::CACHE_ENTRIES];
   logic [47:0] entry_mac_mem [arc_pkg::CACHE_ENTRIES];
   logic [47:0] mac_rd_ff;

   // Execute stage
   logic [arc_pkg::CACHE_ENTRIES-1:0] hit_vec;
   logic [arc_pkg::CACHE_ENTRIES-1:0] learn_vec;
   logic [arc_pkg::CACHE_ENTRIES-1:0] sel_vec;
   logic [arc_pkg::IDX_W-1:0]         sel_idx;
   logic                              sel_any;
   logic                              is_lookup;
   logic                              is_request;
   logic                              is_reply;
   logic                              do_write;
   logic                              send_ff;
   logic                              learned_ff;
   logic                              dropped_ff;
   logic                              hit_ff;
   logic                              rsp_valid_ff;

   assign header_ok_in = (req_payload_length >= arc_pkg::MIN_ARP_LENGTH)
                       && (req_hardware_type == arc_pkg::HW_TYPE_ETHERNET)
                       && (req_protocol_type == arc_pkg::PROTO_TYPE_IPV4)
                       && (req_hardware_length == arc_pkg::HW_LEN_ETHERNET)
                       && (req_protocol_length == arc_pkg::PROTO_LEN_IPV4);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff    <= req_command;
         header_ok_ff  <= header_ok_in;
         operation_ff  <= req_operation;
         sender_ip_ff  <= req_sender_ip;
         sender_mac_ff <= req_sender_mac;
         target_ip_ff  <= req_target_ip;
         lookup_ip_ff  <= req_lookup_ip;
      end
   end

   assign is_lookup  = (command_ff == arc_pkg::CMD_LOOKUP) && (lookup_ip_ff != '0);
   assign is_request = (command_ff == arc_pkg::CMD_PACKET) && header_ok_ff
                     && (operation_ff == arc_pkg::OP_REQUEST);
   assign is_reply   = (command_ff == arc_pkg::CMD_PACKET) && header_ok_ff
                     && (operation_ff == arc_pkg::OP_REPLY) && (sender_ip_ff != '0);

   always_comb begin
      for (int i = 0; i < arc_pkg::CACHE_ENTRIES; i++) begin
         hit_vec[i]   = (entry_ip_ff[i] == lookup_ip_ff);
         learn_vec[i] = (entry_ip_ff[i] == '0) || (entry_ip_ff[i] == sender_ip_ff);
      end
   end

   assign sel_vec = (command_ff == arc_pkg::CMD_LOOKUP) ? hit_vec : learn_vec;
   assign sel_any = |sel_vec;

   // Priority encode: lowest matching slot wins.
   always_comb begin
      sel_idx = '0;
      for (int i = arc_pkg::CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (sel_vec[i]) sel_idx = arc_pkg::IDX_W'(i);
      end
   end

   assign do_write = cmd.exec && is_reply && sel_any;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < arc_pkg::CACHE_ENTRIES; i++) begin
            entry_ip_ff[i] <= '0;
         end
      end else if (do_write) begin
         entry_ip_ff[sel_idx] <= sender_ip_ff;
      end
   end

   // MAC store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_write) entry_mac_mem[sel_idx] <= sender_mac_ff;
      if (cmd.exec) mac_rd_ff <= entry_mac_mem[sel_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         send_ff    <= is_request && (target_ip_ff == own_ip);
         learned_ff <= is_reply && sel_any;
         dropped_ff <= is_reply && !sel_any;
         hit_ff     <= is_lookup && sel_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_send_reply     <= send_ff;
         rsp_reply_dest_mac <= send_ff ? sender_mac_ff : '0;
         rsp_reply_dest_ip  <= send_ff ? sender_ip_ff : '0;
         rsp_learned        <= learned_ff;
         rsp_learn_dropped  <= dropped_ff;
         rsp_lookup_hit     <= hit_ff;
         rsp_lookup_mac     <= hit_ff ? mac_rd_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.rsp_busy = rsp_valid_ff;

endmodule

// ----- rtl/core/arp_responder_and_cache.sv -----
// Top level of the ARP responder and cache: register port, controller
// and datapath. Depends on arc_pkg, arc_ctrl, arc_datapath and the macros.
// Usage:
//  - Input channel (req_*): one transaction is either a parsed ARP packet
//    (req_command = 0) or a cache lookup (req_command = 1); it is taken at
//    an edge where req_valid is high and req_stall is low.
//  - Result channel (rsp_*): exactly one result per input transaction, in
//    order, taken at an edge where rsp_valid is high and rsp_stall is low.
//  - Register port: APB style, own_ip at byte 0x0, own_mac at byte 0x8
//    (only paddr[3] is decoded), 64-bit data, pready tied high.
//  - Each transaction is latched, then searched and used to update the cache,
//    then moved to the output register once that register is free; the single
//    search unit (32-way compare plus priority encode, then cache write or MAC
//    read) serves one transaction at a time, taking the next as a result loads.
//  - The next transaction is taken while a finished result still waits in
//    the output register; with rsp_stall held high the block takes one
//    more, finishes it, then stalls the input until the output drains.
//  - Reset empties the cache (all entry IPs zero) and clears own_ip and
//    own_mac; no clearing pass is needed, the block is ready at once.
//  - Write the registers only while the block is idle.
`include "arp_responder_and_cache_macros.svh"

module arp_responder_and_cache (
   input  logic                            clock,
   input  logic                            reset,
   // Register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [arc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [arc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [arc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   // Input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [10:0]                     req_payload_length,
   input  logic [15:0]                     req_hardware_type,
   input  logic [15:0]                     req_protocol_type,
   input  logic [7:0]                      req_hardware_length,
   input  logic [7:0]                      req_protocol_length,
   input  logic [15:0]                     req_operation,
   input  logic [31:0]                     req_sender_ip,
   input  logic [47:0]                     req_sender_mac,
   input  logic [31:0]                     req_target_ip,
   input  logic [31:0]                     req_lookup_ip,
   // Result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_send_reply,
   output logic [47:0]                     rsp_reply_dest_mac,
   output logic [31:0]                     rsp_reply_dest_ip,
   output logic                            rsp_learned,
   output logic                            rsp_learn_dropped,
   output logic                            rsp_lookup_hit,
   output logic [47:0]                     rsp_lookup_mac
);

   logic [31:0]             own_ip_ff;
   logic [47:0]             own_mac_ff;
   logic                    csr_write;
   logic                    csr_index;
   arc_pkg::arc_cmd_type    cmd;
   arc_pkg::arc_status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // Registers sit 8 bytes apart; the lower address bits are ignored.
   assign csr_index = paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            arc_pkg::REG_OWN_IP:  own_ip_ff  <= pwdata[31:0];
            arc_pkg::REG_OWN_MAC: own_mac_ff <= pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         arc_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip_ff};
         arc_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac_ff};
         default:              prdata = '0;
      endcase
   end

   // Sequence each transaction: take it, search and update, deliver.
   arc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   arc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .own_ip              (own_ip_ff),
      .req_command         (req_command),
      .req_payload_length  (req_payload_length),
      .req_hardware_type   (req_hardware_type),
      .req_protocol_type   (req_protocol_type),
      .req_hardware_length (req_hardware_length),
      .req_protocol_length (req_protocol_length),
      .req_operation       (req_operation),
      .req_sender_ip       (req_sender_ip),
      .req_sender_mac      (req_sender_mac),
      .req_target_ip       (req_target_ip),
      .req_lookup_ip       (req_lookup_ip),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_reply      (rsp_send_reply),
      .rsp_reply_dest_mac  (rsp_reply_dest_mac),
      .rsp_reply_dest_ip   (rsp_reply_dest_ip),
      .rsp_learned         (rsp_learned),
      .rsp_learn_dropped   (rsp_learn_dropped),
      .rsp_lookup_hit      (rsp_lookup_hit),
      .rsp_lookup_mac      (rsp_lookup_mac)
   );

   // A result reports at most one event.
   `ARC_ASSERT_NOW(a_one_event, clock, reset, rsp_valid,
      $countones({rsp_send_reply, rsp_learned, rsp_learn_dropped, rsp_lookup_hit}) <= 1,
      "result reports more than one event")

   // A lookup MAC shows only with a hit, a reply address only with a send.
   `ARC_ASSERT_NOW(a_zero_fields, clock, reset, rsp_valid,
      (rsp_lookup_hit || rsp_lookup_mac == '0) && (rsp_send_reply || rsp_reply_dest_ip == '0),
      "result field set without its flag")

   // A taken transaction keeps the search unit busy for the next cycle.
   `ARC_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall,
      "transaction taken while search unit busy")

   // Loading the output register always presents a result.
   `ARC_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load, rsp_valid,
      "loaded result not presented")

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for arp_responder_and_cache: directed table, then random phases over
// several own_ip/own_mac settings; results checked against a predictor or typed row.
// Depends on arc_pkg and the arp_responder_and_cache RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 900000;
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 256;
   localparam int POOL_SIZE       = 48;
   localparam int DRAIN_CYCLES    = 8;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [31:0] DIRECTED_OWN_IP  = 32'hC0A8_0001;
   localparam logic [47:0] DIRECTED_OWN_MAC = 48'h0200_0000_0001;

   // One input transaction: either a parsed ARP packet or a cache lookup.
   typedef struct packed {
      logic        command;
      logic [10:0] payload_length;
      logic [15:0] hardware_type;
      logic [15:0] protocol_type;
      logic [7:0]  hardware_length;
      logic [7:0]  protocol_length;
      logic [15:0] operation;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip;
      logic [31:0] lookup_ip;
   } arp_item_type;

   // One result transaction.
   typedef struct packed {
      logic        send_reply;
      logic [47:0] reply_dest_mac;
      logic [31:0] reply_dest_ip;
      logic        learned;
      logic        learn_dropped;
      logic        lookup_hit;
      logic [47:0] lookup_mac;
   } arp_outcome_type;

   // Directed stimulus row; a typed outcome replaces the prediction.
   typedef struct {
      arp_item_type    item;
      bit              typed;
      arp_outcome_type outcome;
   } directed_row_type;

   localparam arp_outcome_type QUIET = '0;

   logic clock;
   logic reset;

   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [arc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [arc_pkg::CSR_DATA_W-1:0] pwdata;
   logic [arc_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [10:0] req_payload_length;
   logic [15:0] req_hardware_type;
   logic [15:0] req_protocol_type;
   logic [7:0]  req_hardware_length;
   logic [7:0]  req_protocol_length;
   logic [15:0] req_operation;
   logic [31:0] req_sender_ip;
   logic [47:0] req_sender_mac;
   logic [31:0] req_target_ip;
   logic [31:0] req_lookup_ip;

   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_send_reply;
   logic [47:0] rsp_reply_dest_mac;
   logic [31:0] rsp_reply_dest_ip;
   logic        rsp_learned;
   logic        rsp_learn_dropped;
   logic        rsp_lookup_hit;
   logic [47:0] rsp_lookup_mac;

   // Predictor state: register copies and the address cache.
   logic [31:0] own_ip_q;
   logic [47:0] own_mac_q;
   logic [31:0] cache_ip [arc_pkg::CACHE_ENTRIES];
   logic [47:0] cache_mac [arc_pkg::CACHE_ENTRIES];
   logic [31:0] ip_pool [POOL_SIZE];

   arp_outcome_type  pending_outcomes [$];
   directed_row_type directed_rows [$];

   int error_count = 0;
   int cycle_count = 0;
   bit sender_gaps_on = 1'b1;
   bit receiver_stalls_on = 1'b1;

   arp_responder_and_cache uut (
      .clock               (clock),
      .reset               (reset),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_payload_length  (req_payload_length),
      .req_hardware_type   (req_hardware_type),
      .req_protocol_type   (req_protocol_type),
      .req_hardware_length (req_hardware_length),
      .req_protocol_length (req_protocol_length),
      .req_operation       (req_operation),
      .req_sender_ip       (req_sender_ip),
      .req_sender_mac      (req_sender_mac),
      .req_target_ip       (req_target_ip),
      .req_lookup_ip       (req_lookup_ip),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_reply      (rsp_send_reply),
      .rsp_reply_dest_mac  (rsp_reply_dest_mac),
      .rsp_reply_dest_ip   (rsp_reply_dest_ip),
      .rsp_learned         (rsp_learned),
      .rsp_learn_dropped   (rsp_learn_dropped),
      .rsp_lookup_hit      (rsp_lookup_hit),
      .rsp_lookup_mac      (rsp_lookup_mac)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Compute the result of one transaction and advance the cache copy.
   function automatic arp_outcome_type resolve_arp(arp_item_type item);
      arp_outcome_type outcome;
      bit              header_good;
      bit              matched;
      int              slot;
      outcome = '0;
      matched = 1'b0;
      header_good = item.payload_length >= arc_pkg::MIN_ARP_LENGTH
                    && item.hardware_type == arc_pkg::HW_TYPE_ETHERNET
                    && item.protocol_type == arc_pkg::PROTO_TYPE_IPV4
                    && item.hardware_length == arc_pkg::HW_LEN_ETHERNET
                    && item.protocol_length == arc_pkg::PROTO_LEN_IPV4;
      if (item.command == arc_pkg::CMD_LOOKUP) begin
         // Address zero marks an empty slot, so it never hits.
         if (item.lookup_ip != '0) begin
            for (slot = 0; slot < arc_pkg::CACHE_ENTRIES; slot++) begin
               if (!matched && cache_ip[slot] == item.lookup_ip) begin
                  outcome.lookup_hit = 1'b1;
                  outcome.lookup_mac = cache_mac[slot];
                  matched = 1'b1;
               end
            end
         end
      end else if (header_good) begin
         if (item.operation == arc_pkg::OP_REQUEST) begin
            if (item.target_ip == own_ip_q) begin
               outcome.send_reply     = 1'b1;
               outcome.reply_dest_mac = item.sender_mac;
               outcome.reply_dest_ip  = item.sender_ip;
            end
         end else if (item.operation == arc_pkg::OP_REPLY && item.sender_ip != '0) begin
            // First slot that is empty or already holds the sender wins.
            for (slot = 0; slot < arc_pkg::CACHE_ENTRIES; slot++) begin
               if (!matched && (cache_ip[slot] == '0 || cache_ip[slot] == item.sender_ip)) begin
                  cache_ip[slot]  = item.sender_ip;
                  cache_mac[slot] = item.sender_mac;
                  outcome.learned = 1'b1;
                  matched = 1'b1;
               end
            end
            outcome.learn_dropped = !matched;
         end
      end
      return outcome;
   endfunction

   function automatic logic [47:0] rand_mac();
      return {16'($urandom), $urandom};
   endfunction

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic arp_item_type build_packet(logic [15:0] op, logic [31:0] sip,
                                                 logic [47:0] smac, logic [31:0] tip);
      arp_item_type item;
      item                 = '0;
      item.command         = arc_pkg::CMD_PACKET;
      item.payload_length  = arc_pkg::MIN_ARP_LENGTH;
      item.hardware_type   = arc_pkg::HW_TYPE_ETHERNET;
      item.protocol_type   = arc_pkg::PROTO_TYPE_IPV4;
      item.hardware_length = arc_pkg::HW_LEN_ETHERNET;
      item.protocol_length = arc_pkg::PROTO_LEN_IPV4;
      item.operation       = op;
      item.sender_ip       = sip;
      item.sender_mac      = smac;
      item.target_ip       = tip;
      return item;
   endfunction

   function automatic arp_item_type cache_query(logic [31:0] ip);
      arp_item_type item;
      item           = '0;
      item.command   = arc_pkg::CMD_LOOKUP;
      item.lookup_ip = ip;
      return item;
   endfunction

   function automatic directed_row_type make_row(arp_item_type item, bit typed,
                                                 arp_outcome_type outcome);
      directed_row_type row;
      row.item    = item;
      row.typed   = typed;
      row.outcome = outcome;
      return row;
   endfunction

   // Random transaction: mostly well-formed packets and lookups aimed at
   // the own address and a small address pool, the rest noise or broken.
   function automatic arp_item_type random_item();
      arp_item_type item;
      int           roll;
      int           pick;
      item.command         = 1'($urandom);
      item.payload_length  = 11'($urandom);
      item.hardware_type   = 16'($urandom);
      item.protocol_type   = 16'($urandom);
      item.hardware_length = 8'($urandom);
      item.protocol_length = 8'($urandom);
      item.operation       = 16'($urandom);
      item.sender_ip       = $urandom;
      item.sender_mac      = rand_mac();
      item.target_ip       = $urandom;
      item.lookup_ip       = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 10) return item;

      item.payload_length  = ($urandom_range(0, 3) == 0) ?
                             11'($urandom_range(arc_pkg::MIN_ARP_LENGTH, 2047)) :
                             arc_pkg::MIN_ARP_LENGTH;
      item.hardware_type   = arc_pkg::HW_TYPE_ETHERNET;
      item.protocol_type   = arc_pkg::PROTO_TYPE_IPV4;
      item.hardware_length = arc_pkg::HW_LEN_ETHERNET;
      item.protocol_length = arc_pkg::PROTO_LEN_IPV4;
      pick = $urandom_range(0, 9);
      if (roll < 40) begin
         item.command   = arc_pkg::CMD_PACKET;
         item.operation = arc_pkg::OP_REQUEST;
         if (pick < 7) item.target_ip = own_ip_q;
         else if (pick < 9) item.target_ip = own_ip_q ^ (32'd1 << $urandom_range(0, 31));
      end else if (roll < 70) begin
         item.command   = arc_pkg::CMD_PACKET;
         item.operation = arc_pkg::OP_REPLY;
         if (pick < 7) item.sender_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
         else if (pick == 9) item.sender_ip = '0;
      end else begin
         item.command = arc_pkg::CMD_LOOKUP;
         if (pick < 6) item.lookup_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
         else if (pick == 9) item.lookup_ip = '0;
      end

      // Break one header field now and then.
      if (item.command == arc_pkg::CMD_PACKET && $urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 5))
            0: item.payload_length = 11'($urandom_range(0, arc_pkg::MIN_ARP_LENGTH - 1));
            1: item.hardware_type ^= 16'($urandom_range(1, 65535));
            2: item.protocol_type ^= 16'($urandom_range(1, 65535));
            3: item.hardware_length ^= 8'($urandom_range(1, 255));
            4: item.protocol_length ^= 8'($urandom_range(1, 255));
            default: item.operation = ($urandom_range(0, 1) == 0) ?
                                      16'd0 : 16'($urandom_range(3, 65535));
         endcase
      end
      return item;
   endfunction

   // Write one register through the APB port: setup, then access.
   task automatic write_register(logic reg_index, logic [47:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= arc_pkg::CSR_ADDR_W'({reg_index, 3'b000});
      pwdata  <= arc_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (reg_index == arc_pkg::REG_OWN_IP) own_ip_q = value[31:0];
      else own_mac_q = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Offer one transaction; entered and left at a falling edge.
   task automatic send_item(arp_item_type item, bit typed, arp_outcome_type typed_outcome);
      int              gap;
      arp_outcome_type predicted;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command         <= item.command;
      req_payload_length  <= item.payload_length;
      req_hardware_type   <= item.hardware_type;
      req_protocol_type   <= item.protocol_type;
      req_hardware_length <= item.hardware_length;
      req_protocol_length <= item.protocol_length;
      req_operation       <= item.operation;
      req_sender_ip       <= item.sender_ip;
      req_sender_mac      <= item.sender_mac;
      req_target_ip       <= item.target_ip;
      req_lookup_ip       <= item.lookup_ip;
      req_valid           <= 1'b1;
      // Hold the payload until the block takes it.
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = resolve_arp(item);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic string format_outcome(arp_outcome_type o);
      return $sformatf("send=%0b dmac=%h dip=%h learned=%0b dropped=%0b hit=%0b lmac=%h",
                       o.send_reply, o.reply_dest_mac, o.reply_dest_ip, o.learned,
                       o.learn_dropped, o.lookup_hit, o.lookup_mac);
   endfunction

   task automatic record_mismatch(string what, arp_outcome_type want, arp_outcome_type seen);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("mismatch (%s) at cycle %0d", what, cycle_count);
         $display("  expected %s", format_outcome(want));
         $display("  actual   %s", format_outcome(seen));
      end
   endtask

   // Receiver stall: random stall runs, released whenever stalls are off.
   initial begin : stall_driver
      int run;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         run = receiver_stalls_on ? pick_gap() : 0;
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
   end

   // Compare every taken result with the oldest pending one.
   always @(posedge clock) begin : result_check
      arp_outcome_type seen;
      arp_outcome_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen.send_reply     = rsp_send_reply;
         seen.reply_dest_mac = rsp_reply_dest_mac;
         seen.reply_dest_ip  = rsp_reply_dest_ip;
         seen.learned        = rsp_learned;
         seen.learn_dropped  = rsp_learn_dropped;
         seen.lookup_hit     = rsp_lookup_hit;
         seen.lookup_mac     = rsp_lookup_mac;
         if (pending_outcomes.size() == 0) begin
            record_mismatch("result with nothing pending", QUIET, seen);
         end else begin
            want = pending_outcomes.pop_front();
            if (seen.send_reply !== want.send_reply
                || seen.reply_dest_mac !== want.reply_dest_mac
                || seen.reply_dest_ip !== want.reply_dest_ip
                || seen.learned !== want.learned
                || seen.learn_dropped !== want.learn_dropped
                || seen.lookup_hit !== want.lookup_hit
                || seen.lookup_mac !== want.lookup_mac) begin
               record_mismatch("field mismatch", want, seen);
            end
         end
      end
   end

   // Stop a hung run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   initial begin : stimulus
      arp_item_type item;
      logic [31:0]  ip;
      logic [47:0]  mac;
      int           phase;
      int           k;

      // Drive every input to a known value and hold reset.
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_valid           = 1'b0;
      req_command         = arc_pkg::CMD_PACKET;
      req_payload_length  = '0;
      req_hardware_type   = '0;
      req_protocol_type   = '0;
      req_hardware_length = '0;
      req_protocol_length = '0;
      req_operation       = '0;
      req_sender_ip       = '0;
      req_sender_mac      = '0;
      req_target_ip       = '0;
      req_lookup_ip       = '0;
      own_ip_q            = '0;
      own_mac_q           = '0;
      for (k = 0; k < arc_pkg::CACHE_ENTRIES; k++) begin
         cache_ip[k]  = '0;
         cache_mac[k] = '0;
      end
      for (k = 0; k < POOL_SIZE; k++) begin
         do ip_pool[k] = $urandom; while (ip_pool[k] == '0);
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Typed outcomes are the obvious ones: empty cache,
      // rejected headers, ignored opcodes, first learn, request for us.
      directed_rows.push_back(make_row(cache_query('0), 1'b1, QUIET));
      directed_rows.push_back(make_row(cache_query('1), 1'b1, QUIET));
      directed_rows.push_back(make_row(
         build_packet(arc_pkg::OP_REQUEST, 32'h0A00_0001, '1, DIRECTED_OWN_IP), 1'b1,
         '{1'b1, 48'hFFFF_FFFF_FFFF, 32'h0A00_0001, 1'b0, 1'b0, 1'b0, 48'h0}));
      directed_rows.push_back(make_row(
         build_packet(arc_pkg::OP_REQUEST, 32'h0A00_0002, 48'h1,
                      DIRECTED_OWN_IP ^ 32'h8000_0000),
         1'b1, QUIET));
      // Request from an all-zero sender still gets a reply.
      directed_rows.push_back(make_row(
         build_packet(arc_pkg::OP_REQUEST, '0, '0, DIRECTED_OWN_IP), 1'b1,
         '{1'b1, 48'h0, 32'h0, 1'b0, 1'b0, 1'b0, 48'h0}));
      // Reply from address zero is ignored.
      directed_rows.push_back(make_row(
         build_packet(arc_pkg::OP_REPLY, '0, 48'h1234_5678_9ABC, '0), 1'b1, QUIET));
      item = build_packet(arc_pkg::OP_REPLY, '1, 48'h1, '0);
      item.payload_length = '1;
      directed_rows.push_back(make_row(item, 1'b1,
         '{1'b0, 48'h0, 32'h0, 1'b1, 1'b0, 1'b0, 48'h0}));
      directed_rows.push_back(make_row(cache_query('1), 1'b1,
         '{1'b0, 48'h0, 32'h0, 1'b0, 1'b0, 1'b1, 48'h1}));
      directed_rows.push_back(make_row(build_packet(arc_pkg::OP_REPLY, '1, '1, '1),
                                       1'b0, QUIET));
      directed_rows.push_back(make_row(cache_query('1), 1'b0, QUIET));
      directed_rows.push_back(make_row(
         build_packet(arc_pkg::OP_REPLY, 32'h1, 48'hA5A5_A5A5_A5A5, '0), 1'b0, QUIET));
      directed_rows.push_back(make_row(cache_query(32'h1), 1'b0, QUIET));
      directed_rows.push_back(make_row(cache_query(32'h1234_5678), 1'b0, QUIET));
      // Rejected headers: one field off each, cache left alone.
      item = build_packet(arc_pkg::OP_REPLY, 32'h2, 48'h2, '0);
      item.payload_length = arc_pkg::MIN_ARP_LENGTH - 11'd1;
      directed_rows.push_back(make_row(item, 1'b1, QUIET));
      item = build_packet(arc_pkg::OP_REPLY, 32'h2, 48'h2, '0);
      item.hardware_type = 16'h0002;
      directed_rows.push_back(make_row(item, 1'b1, QUIET));
      item = build_packet(arc_pkg::OP_REPLY, 32'h2, 48'h2, '0);
      item.protocol_type = 16'h86DD;
      directed_rows.push_back(make_row(item, 1'b1, QUIET));
      item = build_packet(arc_pkg::OP_REPLY, 32'h2, 48'h2, '0);
      item.hardware_length = 8'd5;
      directed_rows.push_back(make_row(item, 1'b1, QUIET));
      item = build_packet(arc_pkg::OP_REPLY, 32'h2, 48'h2, '0);
      item.protocol_length = '1;
      directed_rows.push_back(make_row(item, 1'b1, QUIET));
      // Opcodes other than request and reply do nothing.
      directed_rows.push_back(make_row(build_packet('0, 32'h2, 48'h2, DIRECTED_OWN_IP),
                                       1'b1, QUIET));
      directed_rows.push_back(make_row(build_packet(16'd3, 32'h2, 48'h2, DIRECTED_OWN_IP),
                                       1'b1, QUIET));
      directed_rows.push_back(make_row(build_packet('1, 32'h2, 48'h2, DIRECTED_OWN_IP),
                                       1'b1, QUIET));
      // Packet fields ride along with a lookup and must be ignored.
      item = build_packet(arc_pkg::OP_REPLY, 32'h3, 48'h3, DIRECTED_OWN_IP);
      item.command   = arc_pkg::CMD_LOOKUP;
      item.lookup_ip = 32'h3;
      directed_rows.push_back(make_row(item, 1'b0, QUIET));
      // And a lookup address rides along with a packet.
      item = build_packet(arc_pkg::OP_REQUEST, 32'h4, 48'h4, DIRECTED_OWN_IP);
      item.lookup_ip = '1;
      directed_rows.push_back(make_row(item, 1'b0, QUIET));
      directed_rows.push_back(make_row(cache_query(32'h2), 1'b0, QUIET));

      write_register(arc_pkg::REG_OWN_IP, {16'h0, DIRECTED_OWN_IP});
      write_register(arc_pkg::REG_OWN_MAC, DIRECTED_OWN_MAC);
      for (k = 0; k < directed_rows.size(); k++) begin
         send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].outcome);
      end
      req_valid <= 1'b0;

      // Random phases; registers change only once every result is back.
      // Phase 1 runs with no idling at all, phases 2 and 3 idle one side.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: begin
               ip  = '0;
               mac = '0;
            end
            2: begin
               ip  = '1;
               mac = '1;
            end
            default: begin
               ip  = $urandom;
               mac = rand_mac();
            end
         endcase
         wait_until_drained();
         sender_gaps_on     = (phase != 1) && (phase != 3);
         receiver_stalls_on = (phase != 1) && (phase != 2);
         write_register(arc_pkg::REG_OWN_IP, {16'h0, ip});
         write_register(arc_pkg::REG_OWN_MAC, mac);
         for (k = 0; k < ITEMS_PER_PHASE; k++) send_item(random_item(), 1'b0, QUIET);
         req_valid <= 1'b0;
      end

      // Drain, then watch a little longer for stray results.
      receiver_stalls_on = 1'b0;
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/arc_pkg.sv
rtl/core/arc_ctrl.sv
rtl/core/arc_datapath.sv
rtl/core/arp_responder_and_cache.sv
tb/sv/testbench.sv
